@@ hw/rtl/morse_keyer_unit_macros.svh @@
// Assertion helpers shared by the keyer RTL.
`ifndef MORSE_KEYER_UNIT_MACROS_SVH
`define MORSE_KEYER_UNIT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define MK_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("keyer check failed");

// Next-cycle implication, quiet during reset.
`define MK_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("keyer check failed");

`endif

@@ hw/rtl/mk_pkg.sv @@
`default_nettype none
package mk_pkg;

  localparam logic [7:0] SPACE_CODE = 8'h20;

  localparam logic [3:0] LEN_WORD = 4'hF;

  // segment kinds, controller to datapath
  localparam logic [2:0] SEG_LEAD = 3'd0;
  localparam logic [2:0] SEG_ELEM = 3'd1;
  localparam logic [2:0] SEG_EGAP = 3'd2;
  localparam logic [2:0] SEG_WORD = 3'd3;
  localparam logic [2:0] SEG_TAIL = 3'd4;

  localparam logic [2:0] UNITS_ONE   = 3'd1;
  localparam logic [2:0] UNITS_THREE = 3'd3;
  localparam logic [2:0] UNITS_SEVEN = 3'd7;

  localparam logic [10:0] DOT_MS_RESET = 11'd60;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic        key_on;
    logic [2:0]  units;
    logic [13:0] duration_ms;
    logic        last_segment;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [2:0] seg;
  } mk_cmd_t;

  typedef struct packed {
    logic lead;
    logic word;
    logic len_zero;
    logic tail;
    logic k_one;
    logic out_free;
  } mk_sts_t;

  // [15:12] length, [6:0] elements, MSB first from bit length-1, 1 = dash
  localparam logic [15:0] CODE_TABLE [256] = '{
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h601E,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'hF000,16'h6031,16'h6012,16'h0000,16'h7009,16'h0000,16'h5008,16'h601E,
    16'h5016,16'h602D,16'h0000,16'h500A,16'h6033,16'h6021,16'h6015,16'h5012,
    16'h501F,16'h500F,16'h5007,16'h5003,16'h5001,16'h5000,16'h5010,16'h5018,
    16'h501C,16'h501E,16'h6038,16'h602A,16'h0000,16'h5011,16'h0000,16'h600C,
    16'h601A,16'h2001,16'h4008,16'h400A,16'h3004,16'h1000,16'h4002,16'h3006,
    16'h4000,16'h2000,16'h4007,16'h3005,16'h4004,16'h2003,16'h2002,16'h3007,
    16'h4006,16'h400D,16'h3002,16'h3000,16'h1001,16'h3001,16'h4001,16'h3003,
    16'h4009,16'h400B,16'h400C,16'h0000,16'h0000,16'h0000,16'h0000,16'h600D,
    16'h0000,16'h2001,16'h4008,16'h400A,16'h3004,16'h1000,16'h4002,16'h3006,
    16'h4000,16'h2000,16'h4007,16'h3005,16'h4004,16'h2003,16'h2002,16'h3007,
    16'h4006,16'h400D,16'h3002,16'h3000,16'h1001,16'h3001,16'h4001,16'h3003,
    16'h4009,16'h400B,16'h400C,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h3000,16'h0000,16'h3000,16'h1001,16'h400C,16'h400C,
    16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h3000,16'h0000,16'h3000,16'h1001,16'h400C,16'h400C,
    16'h0000,16'h0000,16'h0000,16'h4004,16'h0000,16'h2001,16'h0000,16'h0000,
    16'h0000,16'h0000,16'h3000,16'h0000,16'h0000,16'h0000,16'h0000,16'h400C,
    16'h0000,16'h0000,16'h0000,16'h4004,16'h0000,16'h0000,16'h0000,16'h0000,
    16'h0000,16'h2001,16'h3000,16'h0000,16'h4004,16'h0000,16'h4004,16'h400C,
    16'h3002,16'h2001,16'h2001,16'h2001,16'h2001,16'h4004,16'h400A,16'h400A,
    16'h400A,16'h1000,16'h1000,16'h1000,16'h1000,16'h2000,16'h2000,16'h3004,
    16'h3004,16'h2002,16'h2002,16'h3007,16'h3007,16'h3007,16'h3007,16'h0000,
    16'h3002,16'h3001,16'h3001,16'h3001,16'h3001,16'h400B,16'h1001,16'h0000,
    16'h3002,16'h2001,16'h2001,16'h2001,16'h2001,16'h4004,16'h400A,16'h400A,
    16'h400A,16'h1000,16'h1000,16'h1000,16'h1000,16'h2000,16'h2000,16'h3004,
    16'h3004,16'h2002,16'h2002,16'h3007,16'h3007,16'h3007,16'h3007,16'h0000,
    16'h3002,16'h3001,16'h3001,16'h3001,16'h3001,16'h400B,16'h1001,16'h0000
  };

endpackage
`default_nettype wire

@@ hw/rtl/mk_datapath.sv @@
`default_nettype none
module mk_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [10:0]       cfg_wr_data,
  input  wire mk_pkg::in_item_t  in_data,
  input  wire mk_pkg::mk_cmd_t   cmd,
  output mk_pkg::mk_sts_t        sts,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output mk_pkg::out_item_t      out_data
);
  import mk_pkg::*;

  logic [10:0] dot_ms_r, dot_ms_nxt;
  logic        gap_pending_r, gap_pending_nxt;
  logic        lead_r, lead_nxt;
  logic        word_r, word_nxt;
  logic        len_zero_r, len_zero_nxt;
  logic        tail_r, tail_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [6:0]  bits_r, bits_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic [15:0] entry;
  logic [3:0]  len;
  logic        is_space;
  logic        known;
  logic [2:0]  bit_idx;
  out_item_t   seg;
  logic [13:0] dot_x1;

  assign entry    = CODE_TABLE[in_data.char_code];
  assign len      = entry[15:12];
  assign is_space = (in_data.char_code == SPACE_CODE);
  assign known    = (len != 4'd0) && !is_space;
  assign bit_idx  = k_r - 3'd1;
  assign dot_x1   = {3'b000, dot_ms_r};

  // segment built from the current step
  always_comb begin
    seg = '0;
    unique case (cmd.seg)
      SEG_LEAD: begin
        seg.units        = UNITS_THREE;
        seg.last_segment = len_zero_r;
      end
      SEG_ELEM: begin
        seg.key_on       = 1'b1;
        seg.units        = bits_r[bit_idx] ? UNITS_THREE : UNITS_ONE;
        seg.last_segment = (k_r == 3'd1) && !tail_r;
      end
      SEG_EGAP: begin
        seg.units = UNITS_ONE;
      end
      SEG_WORD: begin
        seg.units        = UNITS_SEVEN;
        seg.last_segment = !tail_r;
      end
      SEG_TAIL: begin
        seg.units        = UNITS_THREE;
        seg.last_segment = 1'b1;
      end
      default: begin
        seg = '0;
      end
    endcase
    case (seg.units)
      UNITS_THREE: seg.duration_ms = (dot_x1 << 1) + dot_x1;
      UNITS_SEVEN: seg.duration_ms = (dot_x1 << 3) - dot_x1;
      default:     seg.duration_ms = dot_x1;
    endcase
  end

  always_comb begin
    dot_ms_nxt      = cfg_wr_en ? cfg_wr_data : dot_ms_r;
    gap_pending_nxt = gap_pending_r;
    lead_nxt        = lead_r;
    word_nxt        = word_r;
    len_zero_nxt    = len_zero_r;
    tail_nxt        = tail_r;
    k_nxt           = k_r;
    bits_nxt        = bits_r;
    if (cmd.load) begin
      // owed gap is settled here; a space swallows it
      lead_nxt        = gap_pending_r && !is_space;
      word_nxt        = (len == LEN_WORD);
      len_zero_nxt    = (len == 4'd0);
      tail_nxt        = known && in_data.last_char;
      gap_pending_nxt = known && !in_data.last_char;
      k_nxt           = len[2:0];
      bits_nxt        = entry[6:0];
    end else if (cmd.emit && cmd.seg == SEG_EGAP) begin
      k_nxt = k_r - 3'd1;
    end
    out_data_nxt  = cmd.emit ? seg : out_data_r;
    out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_ms_r      <= DOT_MS_RESET;
      gap_pending_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      dot_ms_r      <= dot_ms_nxt;
      gap_pending_r <= gap_pending_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lead_r     <= lead_nxt;
    word_r     <= word_nxt;
    len_zero_r <= len_zero_nxt;
    tail_r     <= tail_nxt;
    k_r        <= k_nxt;
    bits_r     <= bits_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.lead     = lead_r;
  assign sts.word     = word_r;
  assign sts.len_zero = len_zero_r;
  assign sts.tail     = tail_r;
  assign sts.k_one    = (k_r == 3'd1);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "morse_keyer_unit_macros.svh"

  `MK_ASSERT_IMPLY(a_elem_k_live, clk, rst_n, (cmd.emit && cmd.seg == SEG_ELEM), (k_r != 3'd0))
  `MK_ASSERT_IMPLY(a_tail_no_owed, clk, rst_n, (cmd.emit && cmd.seg == SEG_TAIL), (!gap_pending_r))
  `MK_ASSERT_NEXT(a_last_clears_owed, clk, rst_n, (cmd.load && in_data.last_char), (!gap_pending_r))

endmodule
`default_nettype wire

@@ hw/rtl/mk_ctrl.sv @@
`default_nettype none
module mk_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mk_pkg::mk_sts_t sts,
  output mk_pkg::mk_cmd_t      cmd
);
  import mk_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_LEAD  = 3'd2;
  localparam logic [2:0] S_ELEM  = 3'd3;
  localparam logic [2:0] S_EGAP  = 3'd4;
  localparam logic [2:0] S_WORD  = 3'd5;
  localparam logic [2:0] S_TAIL  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] after_lead;
  logic [2:0] after_body;

  assign after_lead = sts.word ? S_WORD : (sts.len_zero ? S_IDLE : S_ELEM);
  assign after_body = sts.tail ? S_TAIL : S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        state_nxt = sts.lead ? S_LEAD : after_lead;
      end
      S_LEAD: begin
        cmd.seg  = SEG_LEAD;
        cmd.emit = sts.out_free;
        if (sts.out_free) state_nxt = after_lead;
      end
      S_ELEM: begin
        cmd.seg  = SEG_ELEM;
        cmd.emit = sts.out_free;
        if (sts.out_free) state_nxt = sts.k_one ? after_body : S_EGAP;
      end
      S_EGAP: begin
        cmd.seg  = SEG_EGAP;
        cmd.emit = sts.out_free;
        if (sts.out_free) state_nxt = S_ELEM;
      end
      S_WORD: begin
        cmd.seg  = SEG_WORD;
        cmd.emit = sts.out_free;
        if (sts.out_free) state_nxt = after_body;
      end
      S_TAIL: begin
        cmd.seg  = SEG_TAIL;
        cmd.emit = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

`include "morse_keyer_unit_macros.svh"

  `MK_ASSERT_IMPLY(a_emit_has_room, clk, rst_n, (cmd.emit), (sts.out_free))

endmodule
`default_nettype wire

@@ hw/rtl/morse_keyer_unit.sv @@
// Channel  Ports                            Moves
// input    in_valid/in_ready, in_data       one character and its last flag
// result   out_valid/out_ready, out_data    one key segment
// config   cfg_wr_en, cfg_wr_data           dot length in ms, no wait
//
// A character is accepted in S_IDLE, decoded in S_START, then sent as one
// segment per cycle (up to 15) while the result channel has room.
// Reset (synchronous, rst_n low) clears the sequencer, the owed gap and the
// output valid flag, and loads a dot length of 60 ms.
// A stalled result holds the sequencer in place; the next character is taken
// while the last segment of the previous one still waits for its transfer.
`default_nettype none
module morse_keyer_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [10:0]       cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mk_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mk_pkg::out_item_t      out_data
);
  import mk_pkg::*;

  mk_cmd_t cmd;
  mk_sts_t sts;

  mk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mk_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire
